// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the sampler modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside of reset.
`define CICS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sampler assertion failed");

// Checked at every rising edge, reset included.
`define CICS_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("sampler assertion failed");

`endif

// ===== rtl/cics_pkg.sv =====
package cics_pkg;

   localparam int SLOT_W       = 6;
   localparam int WEIGHT_IN_W  = 16;
   localparam int UNIFORM_IN_W = 32;
   localparam int COUNT_W      = 7;
   localparam int CATEGORY_W   = 6;

   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 8;

   localparam int DEF_MAX_CATEGORIES = 64;
   localparam int DEF_WEIGHT_BITS    = 16;
   localparam int DEF_UNIFORM_BITS   = 32;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_DRAW  = 1'b1;

   typedef struct packed {
      logic                    func;
      logic [SLOT_W-1:0]       slot;
      logic [WEIGHT_IN_W-1:0]  weight;
      logic [UNIFORM_IN_W-1:0] uniform;
      logic [COUNT_W-1:0]      count;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic ready;
   } back_status_type;

endpackage

// ===== rtl/cics_front.sv =====
module cics_front #(
   parameter int MAX_CATEGORIES = cics_pkg::DEF_MAX_CATEGORIES
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // slot [5:0], weight [21:6], uniform [53:22], zero [55:54]
   input  logic [cics_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // func [0]
   input  logic                               req_tuser,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [cics_pkg::COUNT_W-1:0]       csr_data,
   input  cics_pkg::queue_status_type         q_status,
   input  cics_pkg::back_status_type          back_status,
   output logic                               push,
   output cics_pkg::cmd_type                  push_cmd
);
   import cics_pkg::*;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] count_used;
   logic [SLOT_W-1:0]  slot;
   logic               slot_ok;

   assign csr_ready = 1'b1;
   assign count_in  = (csr_valid && csr_ready) ? csr_data : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_W'(1);
      end else begin
         count_ff <= count_in;
      end
   end

   always_comb begin
      priority if (count_ff == '0) begin
         count_used = COUNT_W'(1);
      end else if (32'(count_ff) > MAX_CATEGORIES) begin
         count_used = COUNT_W'(MAX_CATEGORIES);
      end else begin
         count_used = count_ff;
      end
   end

   assign slot    = req_tdata[SLOT_W-1:0];
   assign slot_ok = 32'(slot) < MAX_CATEGORIES;

   assign req_tready = !q_status.full && back_status.ready;

   // Writes to slots outside the table are taken and dropped here.
   assign push = req_tvalid && req_tready && (req_tuser == FUNC_DRAW || slot_ok);

   assign push_cmd.func    = req_tuser;
   assign push_cmd.slot    = slot;
   assign push_cmd.weight  = req_tdata[SLOT_W +: WEIGHT_IN_W];
   assign push_cmd.uniform = req_tdata[SLOT_W + WEIGHT_IN_W +: UNIFORM_IN_W];
   assign push_cmd.count   = count_used;

endmodule

// ===== rtl/cics_queue.sv =====
module cics_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  cics_pkg::cmd_type          push_cmd,
   input  logic                       pop,
   output cics_pkg::cmd_type          head,
   output cics_pkg::queue_status_type q_status
);
   import cics_pkg::*;
   `include "assert_macros.svh"

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      logic [QPTR_W-1:0] r;
      if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + QPTR_W'(1);
      end
      return r;
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head           = entry_ff[rd_ptr_ff];
   assign q_status.full  = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign q_status.empty = count_ff == '0;

   `CICS_ASSERT(a_no_overflow, clock, reset, push |-> (count_ff != QCNT_W'(QUEUE_DEPTH)))
   `CICS_ASSERT(a_no_underflow, clock, reset, pop |-> (count_ff != '0))
   `CICS_ASSERT(a_ptr_match, clock, reset, ((count_ff == '0) || (count_ff == QCNT_W'(QUEUE_DEPTH))) |-> (wr_ptr_ff == rd_ptr_ff))

endmodule

// ===== rtl/cics_back.sv =====
module cics_back #(
   parameter int MAX_CATEGORIES = cics_pkg::DEF_MAX_CATEGORIES,
   parameter int WEIGHT_BITS    = cics_pkg::DEF_WEIGHT_BITS,
   parameter int UNIFORM_BITS   = cics_pkg::DEF_UNIFORM_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  cics_pkg::cmd_type                head,
   input  cics_pkg::queue_status_type       q_status,
   output logic                             pop,
   output cics_pkg::back_status_type        back_status,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // category [5:0], zero [7:6]
   output logic [cics_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // empty_flag [0]
   output logic                             rsp_tuser
);
   import cics_pkg::*;
   `include "assert_macros.svh"

   localparam int IDX_W = $clog2(MAX_CATEGORIES);
   localparam int TOT_W = WEIGHT_BITS + $clog2(MAX_CATEGORIES);
   localparam int LHS_W = TOT_W + UNIFORM_BITS;
   localparam int BIT_W = $clog2(UNIFORM_BITS);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SUM,
      ST_MUL,
      ST_SRCH,
      ST_DONE
   } st_type;

   st_type                  state_ff, state_in;
   logic [IDX_W-1:0]        clr_ff, clr_in;
   logic [COUNT_W-1:0]      idx_ff, idx_in;
   logic [COUNT_W-1:0]      n_ff, n_in;
   logic [UNIFORM_BITS-1:0] u_ff, u_in;
   logic [TOT_W-1:0]        total_ff, total_in;
   logic [TOT_W-1:0]        cum_ff, cum_in;
   logic [LHS_W-1:0]        acc_ff, acc_in;
   logic [BIT_W-1:0]        bit_ff, bit_in;
   logic                    rdv_ff, rdv_in;
   logic [COUNT_W-1:0]      rd_idx_ff, rd_idx_in;
   logic [CATEGORY_W-1:0]   res_cat_ff, res_cat_in;
   logic                    res_empty_ff, res_empty_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CATEGORY_W-1:0]   rsp_cat_ff, rsp_cat_in;
   logic                    rsp_empty_ff, rsp_empty_in;

   logic [WEIGHT_BITS-1:0]  weight_mem [MAX_CATEGORIES];
   logic [WEIGHT_BITS-1:0]  rd_data_ff;
   logic                    issue;
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   logic [WEIGHT_BITS-1:0]  wr_data;
   logic [TOT_W-1:0]        sum_next;
   logic [TOT_W-1:0]        cum_next;
   logic                    at_last;

   assign issue    = ((state_ff == ST_SUM) || (state_ff == ST_SRCH)) && (idx_ff < n_ff);
   assign sum_next = total_ff + TOT_W'(rd_data_ff);
   assign cum_next = cum_ff + TOT_W'(rd_data_ff);
   assign at_last  = rd_idx_ff == (n_ff - COUNT_W'(1));

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      idx_in       = issue ? idx_ff + COUNT_W'(1) : idx_ff;
      n_in         = n_ff;
      u_in         = u_ff;
      total_in     = total_ff;
      cum_in       = cum_ff;
      acc_in       = acc_ff;
      bit_in       = bit_ff;
      rdv_in       = issue;
      rd_idx_in    = idx_ff;
      res_cat_in   = res_cat_ff;
      res_empty_in = res_empty_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_cat_in   = rsp_cat_ff;
      rsp_empty_in = rsp_empty_ff;
      pop          = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = clr_ff;
      wr_data      = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en  = 1'b1;
            clr_in = clr_ff + IDX_W'(1);
            if (clr_ff == IDX_W'(MAX_CATEGORIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_status.empty) begin
               pop = 1'b1;
               if (head.func == FUNC_WRITE) begin
                  wr_en   = 1'b1;
                  wr_addr = IDX_W'(head.slot);
                  wr_data = WEIGHT_BITS'(head.weight);
               end else begin
                  n_in     = head.count;
                  u_in     = UNIFORM_BITS'(head.uniform);
                  idx_in   = '0;
                  total_in = '0;
                  state_in = ST_SUM;
               end
            end
         end
         ST_SUM: begin
            if (rdv_ff) begin
               total_in = sum_next;
               if (at_last) begin
                  idx_in = '0;
                  if (sum_next == '0) begin
                     res_cat_in   = '0;
                     res_empty_in = 1'b1;
                     state_in     = ST_DONE;
                  end else begin
                     acc_in   = '0;
                     bit_in   = '0;
                     state_in = ST_MUL;
                  end
               end
            end
         end
         ST_MUL: begin
            acc_in = {acc_ff[LHS_W-2:0], 1'b0}
                   + (u_ff[UNIFORM_BITS-1] ? LHS_W'(total_ff) : LHS_W'(0));
            u_in   = u_ff << 1;
            bit_in = bit_ff + BIT_W'(1);
            if (bit_ff == BIT_W'(UNIFORM_BITS - 1)) begin
               cum_in   = '0;
               state_in = ST_SRCH;
            end
         end
         ST_SRCH: begin
            if (rdv_ff) begin
               cum_in = cum_next;
               if (at_last || (acc_ff <= {cum_next, {UNIFORM_BITS{1'b0}}})) begin
                  res_cat_in   = CATEGORY_W'(rd_idx_ff);
                  res_empty_in = 1'b0;
                  state_in     = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_cat_in   = res_cat_ff;
               rsp_empty_in = res_empty_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         weight_mem[wr_addr] <= wr_data;
      end
      if (issue) begin
         rd_data_ff <= weight_mem[IDX_W'(idx_ff)];
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      u_ff         <= u_in;
      total_ff     <= total_in;
      cum_ff       <= cum_in;
      acc_ff       <= acc_in;
      bit_ff       <= bit_in;
      rd_idx_ff    <= rd_idx_in;
      res_cat_ff   <= res_cat_in;
      res_empty_ff <= res_empty_in;
      rsp_cat_ff   <= rsp_cat_in;
      rsp_empty_ff <= rsp_empty_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         idx_ff       <= '0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         idx_ff       <= idx_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign back_status.ready = state_ff != ST_CLEAR;
   assign rsp_tvalid        = rsp_valid_ff;
   assign rsp_tdata         = RSP_TDATA_W'(rsp_cat_ff);
   assign rsp_tuser         = rsp_empty_ff;

   `CICS_ASSERT_ALWAYS(a_reset_clear, clock, reset |=> (!rsp_valid_ff && (state_ff == ST_CLEAR)))
   `CICS_ASSERT(a_empty_cat_zero, clock, reset, (rsp_valid_ff && rsp_empty_ff) |-> (rsp_cat_ff == '0))
   `CICS_ASSERT(a_read_in_range, clock, reset, rdv_ff |-> (rd_idx_ff < n_ff))
   `CICS_ASSERT(a_mul_nonzero, clock, reset, (state_ff == ST_MUL) |-> (total_ff != '0))

endmodule

// ===== rtl/categorical_inverse_cdf_sampler.sv =====
// Categorical sampler by inverse-CDF search over a table of unsigned weights. A request with
// func 0 writes one weight slot; a request with func 1 brings a uniform fraction and returns
// the first category whose running weight sum reaches uniform times the total, or category 0
// with the empty flag set when the weights in use sum to zero. After reset a clearing pass
// zeroes the weight memory, one entry per cycle, while req_tready stays low. A write is done
// in the engine as it leaves the queue. A draw over n categories in use leaves the queue,
// sums the n weights, forms the shift-add product of uniform and total, searches the running
// sums, and hands the result over; a zero total skips the product and the search. Both passes
// are paced by the single read port of the weight memory, and a draw waits longer while an
// earlier result is held by rsp_tready. A two-entry queue lets requests be taken while a draw
// runs or a result waits.
module categorical_inverse_cdf_sampler #(
   parameter int MAX_CATEGORIES = cics_pkg::DEF_MAX_CATEGORIES,
   parameter int WEIGHT_BITS    = cics_pkg::DEF_WEIGHT_BITS,
   parameter int UNIFORM_BITS   = cics_pkg::DEF_UNIFORM_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // slot [5:0], weight [21:6], uniform [53:22], zero [55:54]
   input  logic [cics_pkg::REQ_TDATA_W-1:0] req_tdata,
   // func [0]
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // category [5:0], zero [7:6]
   output logic [cics_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // empty_flag [0]
   output logic                             rsp_tuser,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cics_pkg::COUNT_W-1:0]     csr_data
);
   import cics_pkg::*;

   queue_status_type q_status;
   back_status_type  back_status;
   logic             push;
   logic             pop;
   cmd_type          push_cmd;
   cmd_type          head;

   cics_front #(
      .MAX_CATEGORIES(MAX_CATEGORIES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .q_status   (q_status),
      .back_status(back_status),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   cics_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_cmd(push_cmd),
      .pop     (pop),
      .head    (head),
      .q_status(q_status)
   );

   cics_back #(
      .MAX_CATEGORIES(MAX_CATEGORIES),
      .WEIGHT_BITS   (WEIGHT_BITS),
      .UNIFORM_BITS  (UNIFORM_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_status   (q_status),
      .pop        (pop),
      .back_status(back_status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== dv/categorical_inverse_cdf_sampler_tb.sv =====
module categorical_inverse_cdf_sampler_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cics_pkg::*;

   localparam int NUM_SLOTS    = DEF_MAX_CATEGORIES;
   localparam int DRAIN_CYCLES = 250;
   localparam int MAX_REPORTS  = 10;

   typedef struct {
      logic [CATEGORY_W-1:0] category;
      logic                  empty_flag;
   } draw_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = FUNC_WRITE;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [COUNT_W-1:0]     csr_data = '0;

   logic [WEIGHT_IN_W-1:0] model_weights [NUM_SLOTS];
   logic [COUNT_W-1:0]     model_count;
   draw_result_type        pending_draws[$];
   int                     failures = 0;
   int                     idle_pct = 29;
   int                     hold_left = 0;

   categorical_inverse_cdf_sampler uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("categorical_inverse_cdf_sampler_tb NOT OK");
      $finish;
   end

   function automatic draw_result_type predict_draw(input logic [UNIFORM_IN_W-1:0] uniform);
      int unsigned     n;
      int unsigned     j;
      logic [63:0]     total;
      logic [63:0]     cum;
      logic [63:0]     lhs;
      draw_result_type r;
      n = (model_count == 0) ? 1 : ((model_count > NUM_SLOTS) ? NUM_SLOTS : model_count);
      total = 0;
      for (int k = 0; k < n; k++) total += model_weights[k];
      r.category = '0;
      r.empty_flag = (total == 0);
      if (total != 0) begin
         lhs = total * uniform;
         j = 0;
         cum = model_weights[0];
         while (j < n - 1 && lhs > (cum << UNIFORM_IN_W)) begin
            j++;
            cum += model_weights[j];
         end
         r.category = j[CATEGORY_W-1:0];
      end
      return r;
   endfunction

   // Leaves req_tvalid high after the handshake; the caller must present the next
   // transaction or lower req_tvalid in the same time step.
   task automatic send_item(input logic func, input logic [SLOT_W-1:0] slot,
                            input logic [WEIGHT_IN_W-1:0] weight,
                            input logic [UNIFORM_IN_W-1:0] uniform);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {2'b00, uniform, weight, slot};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (func == FUNC_WRITE) model_weights[slot] = weight;
      else pending_draws.push_back(predict_draw(uniform));
   endtask

   task automatic set_category_count(input logic [COUNT_W-1:0] value);
      req_tvalid <= 1'b0;
      while (pending_draws.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      model_count = value;
   endtask

   function automatic logic [WEIGHT_IN_W-1:0] pick_weight();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 15) return '0;
      if (roll < 25) return '1;
      if (roll < 55) return WEIGHT_IN_W'($urandom_range(15));
      return WEIGHT_IN_W'($urandom);
   endfunction

   function automatic logic [UNIFORM_IN_W-1:0] pick_uniform();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 10) return '0;
      if (roll < 20) return '1;
      return $urandom;
   endfunction

   task automatic run_random_phase(input logic [COUNT_W-1:0] count, input int items);
      int unsigned n;
      logic [SLOT_W-1:0] slot;
      set_category_count(count);
      n = (count == 0) ? 1 : ((count > NUM_SLOTS) ? NUM_SLOTS : count);
      repeat (items) begin
         if ($urandom_range(99) < 35) begin
            slot = SLOT_W'(($urandom_range(99) < 80) ? $urandom_range(n - 1) : $urandom);
            send_item(FUNC_WRITE, slot, pick_weight(), $urandom);
         end else begin
            send_item(FUNC_DRAW, SLOT_W'($urandom), WEIGHT_IN_W'($urandom), pick_uniform());
         end
      end
   endtask

   task automatic test_reset_draw();
      send_item(FUNC_DRAW, '0, '0, 32'h1234_5678);
   endtask

   task automatic test_table_edges();
      set_category_count(7'd4);
      send_item(FUNC_WRITE, 6'd1, 16'd5, '0);
      send_item(FUNC_WRITE, 6'd3, 16'd7, '0);
      // A zero uniform lands on the first category even though its weight is zero.
      send_item(FUNC_DRAW, '0, '0, '0);
      send_item(FUNC_DRAW, '0, '0, '1);
      send_item(FUNC_DRAW, '0, '0, 32'h8000_0000);
      send_item(FUNC_DRAW, '1, '1, 32'h4000_0000);
      send_item(FUNC_WRITE, 6'd0, '1, '1);
      send_item(FUNC_WRITE, 6'd63, '1, '0);
      send_item(FUNC_DRAW, '0, '0, '1);
      set_category_count(7'd0);
      send_item(FUNC_DRAW, '0, '0, 32'hDEAD_BEEF);
      set_category_count(7'd127);
      send_item(FUNC_DRAW, '0, '0, '1);
      send_item(FUNC_DRAW, '0, '0, '0);
      send_item(FUNC_WRITE, 6'd0, '0, '0);
      send_item(FUNC_WRITE, 6'd1, '0, '0);
      send_item(FUNC_WRITE, 6'd3, '0, '0);
      send_item(FUNC_DRAW, '0, '0, 32'h0000_0001);
      send_item(FUNC_WRITE, 6'd63, '0, '0);
      send_item(FUNC_DRAW, '0, '0, '1);
      set_category_count(7'd64);
      send_item(FUNC_WRITE, 6'd62, 16'd1, '0);
      send_item(FUNC_DRAW, '0, '0, '1);
   endtask

   task automatic test_random_traffic();
      run_random_phase(7'd1, 90);
      run_random_phase(7'd2, 90);
      idle_pct = 0;
      run_random_phase(7'd64, 90);
      idle_pct = 29;
      run_random_phase(7'd127, 90);
      run_random_phase(7'd0, 90);
      run_random_phase(COUNT_W'($urandom_range(3, 63)), 90);
      run_random_phase(COUNT_W'($urandom_range(0, 127)), 90);
   endtask

   task automatic test_output_backpressure();
      set_category_count(7'd3);
      hold_left = 400;
      repeat (16) begin
         send_item(FUNC_DRAW, SLOT_W'($urandom), WEIGHT_IN_W'($urandom), pick_uniform());
      end
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= idle_pct);
         end
      end
   end

   always @(posedge clock) begin : check_results
      draw_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_draws.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("unexpected result transaction: category %0d empty_flag %0b",
                        rsp_tdata[CATEGORY_W-1:0], rsp_tuser);
         end else begin
            want = pending_draws.pop_front();
            if (rsp_tdata[CATEGORY_W-1:0] !== want.category || rsp_tuser !== want.empty_flag) begin
               failures++;
               if (failures <= MAX_REPORTS)
                  $display("mismatch: expected category %0d empty_flag %0b, got %0d %0b",
                           want.category, want.empty_flag,
                           rsp_tdata[CATEGORY_W-1:0], rsp_tuser);
            end
         end
      end
   end

   initial begin
      for (int k = 0; k < NUM_SLOTS; k++) model_weights[k] = '0;
      model_count = 7'd1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_draw();
      test_table_edges();
      test_random_traffic();
      test_output_backpressure();
      req_tvalid <= 1'b0;
      while (pending_draws.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("categorical_inverse_cdf_sampler_tb OK");
      end else begin
         $display("categorical_inverse_cdf_sampler_tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/cics_pkg.sv
rtl/cics_front.sv
rtl/cics_queue.sv
rtl/cics_back.sv
rtl/categorical_inverse_cdf_sampler.sv
dv/categorical_inverse_cdf_sampler_tb.sv
